### sv/lfuc_pkg.sv
package lfuc_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam int IDX_MAX_W = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                 upd;
    logic                 ins;
    logic                 age_all;
    logic                 hit;
    logic [IDX_MAX_W-1:0] idx;
    logic [IDX_MAX_W-1:0] rank;
    logic [VAL_W-1:0]     hit_value;
  } sel_t;

endpackage

### sv/lfuc_select.sv
module lfuc_select #(
  parameter int ENTRIES = 16,
  parameter int COUNT_BITS = 16,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [ENTRIES-1:0]           valid,
  input  logic [lfuc_pkg::KEY_W-1:0]   key [ENTRIES],
  input  logic [lfuc_pkg::VAL_W-1:0]   value [ENTRIES],
  input  logic [COUNT_BITS-1:0]        count [ENTRIES],
  input  logic [IDX_W-1:0]             rank [ENTRIES],
  input  lfuc_pkg::req_t               req,
  input  logic [lfuc_pkg::CAP_W-1:0]   cap,
  output lfuc_pkg::sel_t               sel
);
  import lfuc_pkg::*;

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [ENTRIES-1:0] match_oh;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] tgt_oh;
  logic               hit;
  logic               full;
  logic               beats;
  logic [OCC_W-1:0]   occ;
  logic [VAL_W-1:0]   hit_value;
  logic [IDX_W-1:0]   tgt_idx;
  logic [IDX_W-1:0]   tgt_rank;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_oh[i] = valid[i] && (key[i] == req.key);
    end
    hit = |match_oh;

    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_oh[i]) begin
        hit_value = hit_value | value[i];
      end
    end

    occ  = OCC_W'($countones(valid));
    full = (CMP_W'(occ) >= CMP_W'(cap)) || (occ == OCC_W'(ENTRIES));

    // lowest clear bit of the valid vector
    free_oh = ~valid & (valid + 1'b1);

    // ranks of valid entries are distinct, so exactly one entry wins if any entry is valid
    for (int i = 0; i < ENTRIES; i++) begin
      beats = valid[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (j != i && valid[j]) begin
          if (!((count[i] < count[j]) ||
                ((count[i] == count[j]) && (rank[i] > rank[j])))) begin
            beats = 1'b0;
          end
        end
      end
      victim_oh[i] = beats;
    end

    if (hit) begin
      tgt_oh = match_oh;
    end else if (full) begin
      tgt_oh = victim_oh;
    end else begin
      tgt_oh = free_oh;
    end

    tgt_idx  = '0;
    tgt_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tgt_oh[i]) begin
        tgt_idx  = tgt_idx | IDX_W'(i);
        tgt_rank = tgt_rank | rank[i];
      end
    end

    sel.hit       = hit;
    sel.hit_value = hit ? hit_value : MISS_VALUE;
    sel.upd       = (req.op == OP_GET) ? hit : (cap != '0);
    sel.ins       = !hit;
    sel.age_all   = !hit && !full;
    sel.idx       = IDX_MAX_W'(tgt_idx);
    sel.rank      = IDX_MAX_W'(tgt_rank);
  end

endmodule

### sv/lfuc_store.sv
module lfuc_store #(
  parameter int ENTRIES = 16,
  parameter int COUNT_BITS = 16,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         apply,
  input  lfuc_pkg::req_t               req,
  input  lfuc_pkg::sel_t               sel,
  output logic [ENTRIES-1:0]           valid,
  output logic [lfuc_pkg::KEY_W-1:0]   key [ENTRIES],
  output logic [lfuc_pkg::VAL_W-1:0]   value [ENTRIES],
  output logic [COUNT_BITS-1:0]        count [ENTRIES],
  output logic [IDX_W-1:0]             rank [ENTRIES]
);
  import lfuc_pkg::*;

  logic             upd;
  logic [IDX_W-1:0] tgt;
  logic [IDX_W-1:0] tgt_rank;

  assign upd      = apply && sel.upd;
  assign tgt      = sel.idx[IDX_W-1:0];
  assign tgt_rank = sel.rank[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (upd && sel.ins) begin
      valid[tgt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (IDX_W'(j) == tgt) begin
          rank[j] <= '0;
          if (sel.ins) begin
            key[j]   <= req.key;
            count[j] <= COUNT_BITS'(1);
          end else if (count[j] != '1) begin
            count[j] <= count[j] + 1'b1;
          end
          if (req.op == OP_PUT) begin
            value[j] <= req.value;
          end
        end else if (valid[j] && (sel.age_all || (rank[j] < tgt_rank))) begin
          rank[j] <= rank[j] + 1'b1;
        end
      end
    end
  end

endmodule

### sv/lfu_cache_lru_tiebreak.sv
// Channel  Direction  Ports                       Payload
// s        in         s_tvalid s_tready s_tdata   tdata: lookup_key, store_value
//                     s_tuser                     tuser: op
// m        out        m_tvalid m_tready m_tdata   tdata: read_value
//                     m_tuser                     tuser: found
// cfg      in         cfg_valid cfg_ready         capacity_in_use
//                     cfg_data
//
// One transaction per cycle unless a get waits on a stalled m side: lookup, victim choice
// and update of all entries happen in a single cycle between the input register and the
// state/result registers. A get yields one result transaction; a put yields none.
// Synchronous reset invalidates every entry and sets the capacity to 16.
// A stalled m side holds a get in the input register and stalls s; puts do not wait on m.
module lfu_cache_lru_tiebreak #(
  parameter int ENTRIES = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [63:0]                  s_tdata,   // lookup_key, store_value
  input  logic                         s_tuser,   // op
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,   // read_value
  output logic                         m_tuser,   // found
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfuc_pkg::CAP_W-1:0]   cfg_data
);
  import lfuc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic               in_vld;
  req_t               req;
  logic [CAP_W-1:0]   cap;
  logic               out_free;
  logic               process;
  sel_t               sel;
  logic [ENTRIES-1:0] valid;
  logic [KEY_W-1:0]   key [ENTRIES];
  logic [VAL_W-1:0]   value [ENTRIES];
  logic [COUNT_BITS-1:0] count [ENTRIES];
  logic [IDX_W-1:0]   rank [ENTRIES];

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign process   = in_vld && ((req.op == OP_PUT) || out_free);
  assign s_tready  = !in_vld || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.op    <= s_tuser;
      req.key   <= s_tdata[31:0];
      req.value <= s_tdata[63:32];
    end
  end

  lfuc_select #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_select (
    .valid (valid),
    .key   (key),
    .value (value),
    .count (count),
    .rank  (rank),
    .req   (req),
    .cap   (cap),
    .sel   (sel)
  );

  lfuc_store #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .apply (process),
    .req   (req),
    .sel   (sel),
    .valid (valid),
    .key   (key),
    .value (value),
    .count (count),
    .rank  (rank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (process && (req.op == OP_GET)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && (req.op == OP_GET)) begin
      m_tuser <= sel.hit;
      m_tdata <= sel.hit_value;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lfuc_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int COUNT_BITS   = 16;
  localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam int POOL_SIZE    = 20;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT  = 50;
  localparam int EXP_DEPTH    = 16;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } lookup_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [63:0]      s_tdata   = '0;
  logic             s_tuser   = OP_GET;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [31:0]      m_tdata;
  logic             m_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  bit               line_valid [ENTRIES];
  logic [KEY_W-1:0] line_key   [ENTRIES];
  logic [VAL_W-1:0] line_value [ENTRIES];
  int unsigned      line_uses  [ENTRIES];
  int unsigned      line_age   [ENTRIES];
  int unsigned      capacity   = CAP_RESET;

  lookup_t          exp_buf [EXP_DEPTH];
  int               exp_wr       = 0;
  int               exp_rd       = 0;
  lookup_t          head;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int               errors       = 0;
  int               stall_cycles = 0;
  int               hold_count   = 0;
  logic             no_idle      = 1'b0;
  logic             hold_req     = 1'b0;

  always #6 clk = ~clk;

  lfu_cache_lru_tiebreak #(
    .ENTRIES(ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic void expect_lookup(input logic f, input logic [VAL_W-1:0] v);
    lookup_t e;
    e.found = f;
    e.value = v;
    exp_buf[exp_wr % EXP_DEPTH] = e;
    exp_wr++;
  endfunction

  function automatic int find_line(input logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void touch_line(input int s);
    int unsigned r;
    r = line_age[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_age[i] < r) line_age[i]++;
    end
    line_age[s] = 0;
    if (line_uses[s] < COUNT_MAX) line_uses[s]++;
  endfunction

  function automatic int victim_line();
    int v;
    v = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i]) begin
        if (v < 0 || line_uses[i] < line_uses[v] ||
            (line_uses[i] == line_uses[v] && line_age[i] > line_age[v]))
          v = i;
      end
    end
    return v;
  endfunction

  function automatic void insert_line(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v,
                                      input int unsigned cap);
    int          slot;
    int unsigned used;
    int unsigned r;
    slot = -1;
    used = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i]) used++;
    end
    if (used >= cap) begin
      slot = victim_line();
      r = line_age[slot];
      line_valid[slot] = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && line_age[i] > r) line_age[i]--;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!line_valid[i] && slot < 0) slot = i;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i]) line_age[i]++;
    end
    line_valid[slot] = 1'b1;
    line_key[slot]   = k;
    line_value[slot] = v;
    line_uses[slot]  = 1;
    line_age[slot]   = 0;
  endfunction

  function automatic void predict_cache(input logic op, input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v);
    int          s;
    int unsigned cap;
    s = find_line(k);
    if (op == OP_GET) begin
      if (s >= 0) begin
        touch_line(s);
        expect_lookup(1'b1, line_value[s]);
      end else begin
        expect_lookup(1'b0, MISS_VALUE);
      end
      return;
    end
    cap = (capacity > ENTRIES) ? ENTRIES : capacity;
    if (cap == 0) return;
    if (s >= 0) begin
      line_value[s] = v;
      touch_line(s);
    end else begin
      insert_line(k, v, cap);
    end
  endfunction

  task automatic log_mismatch(input string what);
    if (errors < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic send(input logic op, input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    while (!no_idle && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {v, k};
    do @(posedge clk); while (!s_tready);
    predict_cache(op, k, v);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity = cap;
  endtask

  task automatic test_use_counts();
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    logic [KEY_W-1:0] kc;
    ka = 32'h1234_5678;
    kb = 32'hFEDC_BA98;
    kc = 32'h0BAD_F00D;
    set_capacity(5'd2);
    no_idle <= 1'b1;
    send(OP_PUT, ka, $urandom());
    send(OP_PUT, kb, $urandom());
    repeat (6) send(OP_PUT, ka, $urandom());
    repeat (5) send(OP_PUT, kb, $urandom());
    no_idle <= 1'b0;
    send(OP_GET, kb, $urandom());
    send(OP_GET, ka, $urandom());
    send(OP_GET, kb, $urandom());
    send(OP_PUT, kc, $urandom());
    send(OP_GET, ka, $urandom());
    send(OP_GET, kb, $urandom());
    send(OP_GET, kc, $urandom());
  endtask

  task automatic test_basic_ops();
    set_capacity(5'd16);
    send(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send(OP_PUT, 32'h0000_0000, 32'hA5A5_5A5A);
    send(OP_GET, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_capacity_limits();
    set_capacity(5'd0);
    send(OP_PUT, 32'h0000_0011, 32'h1111_1111);
    send(OP_PUT, 32'h0000_0000, 32'h2222_2222);
    send(OP_GET, 32'h0000_0011, 32'h0000_0000);
    send(OP_GET, 32'h0000_0000, 32'h0000_0000);
    set_capacity(5'd31);
    for (int i = 0; i < 12; i++) send(OP_PUT, 32'h0000_0100 + i, $urandom());
    send(OP_GET, 32'h0000_0100, 32'h0000_0000);
    send(OP_GET, 32'h0000_010B, 32'h0000_0000);
    set_capacity(5'd1);
    send(OP_PUT, 32'h0000_0200, 32'h0BEE_F000);
    send(OP_GET, 32'h0000_0200, 32'h0000_0000);
  endtask

  task automatic test_eviction_order();
    set_capacity(5'd3);
    send(OP_PUT, 32'h0000_0400, $urandom());
    send(OP_PUT, 32'h0000_0401, $urandom());
    send(OP_GET, 32'h0000_0400, $urandom());
    send(OP_PUT, 32'h0000_0402, $urandom());
    send(OP_GET, 32'h0000_0401, $urandom());
    send(OP_PUT, 32'h0000_0403, $urandom());
    for (int i = 0; i < 4; i++) send(OP_GET, 32'h0000_0400 + i, $urandom());
  endtask

  task automatic test_receiver_hold();
    set_capacity(5'd4);
    hold_req <= 1'b1;
    for (int i = 0; i < 24; i++) begin
      send(($urandom_range(99) < 70) ? OP_GET : OP_PUT, 32'h0000_0400 + (i % 6), $urandom());
    end
    hold_req <= 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps[10];
    logic [KEY_W-1:0] k;
    logic             op;
    caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd7, 5'd16, 5'd2, 5'd12, 5'd16};
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      no_idle <= (p == 6);
      repeat (56) begin
        op = ($urandom_range(99) < 55) ? OP_GET : OP_PUT;
        k  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom();
        send(op, k, $urandom());
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      m_tready   <= 1'b0;
    end else begin
      if (!hold_req) hold_count <= 0;
      m_tready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (exp_wr == exp_rd) begin
        log_mismatch($sformatf("unexpected result found=%0b value=%h", m_tuser, m_tdata));
      end else begin
        head = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (m_tuser !== head.found)
          log_mismatch($sformatf("found %0b, want %0b", m_tuser, head.found));
        if (m_tdata !== head.value)
          log_mismatch($sformatf("read_value %h, want %h", m_tdata, head.value));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("lfu_cache_lru_tiebreak test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_use_counts();
    test_basic_ops();
    test_capacity_limits();
    test_eviction_order();
    test_receiver_hold();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("lfu_cache_lru_tiebreak test passed");
    end else begin
      $display("lfu_cache_lru_tiebreak test failed");
    end
    $finish;
  end

endmodule
